// ===== sv/rcfd_pkg.sv =====
// rcfd_pkg: constants, codes and sequencer states for the radio control
// frame channel decoder. No dependencies.
`timescale 1ns / 1ps

package rcfd_pkg;

  // packet framing
  localparam int unsigned PACKET_BYTES     = 22;
  localparam int unsigned STORE_DEPTH      = 20;
  localparam int unsigned STORE_AW         = $clog2(STORE_DEPTH);
  localparam int unsigned NUM_CHANNELS_DEF = 12;
  localparam int unsigned MAX_CHANNELS     = 12;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned VAL_W   = 12;
  localparam int unsigned HOP_P_W = 6;

  // header and packet positions
  localparam logic [6:0]       HEADER_CHAR  = 7'h53;
  localparam logic [POS_W-1:0] POS_FIRST    = 5'd0;
  localparam logic [POS_W-1:0] POS_SWITCHES = 5'd19;
  localparam logic [POS_W-1:0] POS_HOP      = 5'd20;
  localparam logic [POS_W-1:0] POS_LAST     = 5'(PACKET_BYTES - 1);
  localparam logic [STORE_AW-1:0] HI_NIB_BASE = 5'd12;

  // channel values
  localparam logic [VAL_W-1:0] VAL_LOW_EXCL  = 12'd799;
  localparam logic [VAL_W-1:0] VAL_HIGH_EXCL = 12'd2201;
  localparam logic [VAL_W-1:0] SWITCH_ON     = 12'd1850;
  localparam logic [VAL_W-1:0] SWITCH_OFF    = 12'd1150;
  localparam logic [VAL_W-1:0] CENTER        = 12'd1500;
  localparam logic [CH_W-1:0]  MIN_PROP      = 4'd4;
  localparam logic [CH_W-1:0]  MAX_SWITCHES  = 4'd5;
  localparam logic [VAL_W:0]   DEADBAND      = 13'd3;
  localparam logic [VAL_W:0]   BACKOFF       = 13'd2;

  // hop info
  localparam logic [HOP_P_W-1:0] HOP_BASE     = 6'd18;
  localparam logic [3:0]         HOP_CHAN_TAG = 4'h2;

  // result sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CALC,
    ST_OUT
  } seq_state_e;

endpackage

// ===== sv/rcfd_if.sv =====
// rcfd_in_if / rcfd_out_if: valid-ready channels for packet bytes and
// channel results. Depends on rcfd_pkg.
`timescale 1ns / 1ps

interface rcfd_in_if
  import rcfd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              packet_start;

  modport source (output valid, output data_byte, output packet_start, input ready);
  modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface rcfd_out_if
  import rcfd_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel_index;
  logic [VAL_W-1:0]   channel_value;
  logic [HOP_P_W-1:0] hop_period_ms;
  logic               hop_channel_present;
  logic [3:0]         hop_channel;
  logic               last;

  modport source (output valid, output channel_index, output channel_value,
                  output hop_period_ms, output hop_channel_present,
                  output hop_channel, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input hop_period_ms, input hop_channel_present,
                  input hop_channel, input last, output ready);
endinterface

// ===== sv/rc_frame_channel_decoder.sv =====
// rc_frame_channel_decoder: buffers 22-byte radio packets and emits one
// smoothed result word per control channel. Depends on rcfd_pkg, rcfd_if.
`timescale 1ns / 1ps

// Usage
//   byte_i takes one packet byte per word; packet_start marks byte 0 and
//   restarts the position. After byte 21 the position returns to 0.
//   Bytes 0..20 are taken one per cycle while the block is idle and produce no result.
//   When byte 21 closes a packet whose header is 'S', the block drops
//   byte_i.ready and emits NUM_CHANNELS result words on result_o, channel 0
//   first, last set on the final one. Each result passes through ST_RD_LO
//   and ST_RD_HI, two reads of the packet buffer (one read port, low byte
//   then shared nibble byte), ST_CALC through the shared compare/deadband
//   unit, and ST_OUT holding the output register until the receiver takes
//   the word. A packet with a wrong header costs nothing extra.
//   A stall on result_o holds the current word and the sequencer.
//   Reset sets the position to 0, clears the header flag and sets every
//   channel output to 1500; the packet buffer is not cleared since every
//   packet writes each entry before it is read.

module rc_frame_channel_decoder
  import rcfd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcfd_in_if.sink     byte_i,
  rcfd_out_if.source  result_o
);

  localparam int unsigned CH_IDX_W = $clog2(NUM_CHANNELS);
  localparam logic [CH_W-1:0] NUM_CH  = CH_W'(NUM_CHANNELS);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  seq_state_e state_q, state_d;

  logic [POS_W-1:0]    pos_q;
  logic                header_ok_q;
  logic [BYTE_W-1:0]   store_mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   rd_data_q;
  logic [STORE_AW-1:0] rd_addr;
  logic [BYTE_W-1:0]   lo_q;
  logic [BYTE_W-1:0]   switch_q;
  logic [BYTE_W-1:0]   hop_byte_q;
  logic [CH_W-1:0]     cnt_q;
  logic [CH_W-1:0]     ch_q;
  logic [VAL_W-1:0]    chan_out_q [NUM_CHANNELS];

  logic [HOP_P_W-1:0]  hop_period_q;
  logic                hop_present_q;
  logic [3:0]          hop_chan_q;
  logic [VAL_W-1:0]    res_value_q;
  logic                res_last_q;

  logic                in_acc;
  logic                out_acc;
  logic [POS_W-1:0]    pos_eff;
  logic                start_burst;
  logic                in_ready;
  logic                calc_en;
  logic [CH_W-1:0]     cnt_raw;

  // shared value unit
  logic [3:0]          hi_nib;
  logic [VAL_W-1:0]    prop_val;
  logic                is_prop;
  logic [CH_W-1:0]     sw_off;
  logic                is_switch;
  logic                in_range;
  logic                have;
  logic [VAL_W-1:0]    fresh;
  logic [VAL_W-1:0]    cur;
  logic [VAL_W:0]      fresh_x;
  logic [VAL_W:0]      cur_x;
  logic [VAL_W-1:0]    new_val;

  assign in_acc  = byte_i.valid && in_ready;
  assign out_acc = result_o.valid && result_o.ready;

  // effective byte position for the incoming word
  always_comb begin
    pos_eff = byte_i.packet_start ? POS_FIRST : pos_q;
    if (pos_eff > POS_LAST) begin
      pos_eff = POS_LAST;
    end
  end

  assign start_burst = in_acc && (pos_eff == POS_LAST) && header_ok_q;

  // channel count from the high nibble of byte 20, limited to 4..NUM_CHANNELS
  always_comb begin
    cnt_raw = hop_byte_q[7:4];
    if (cnt_raw < MIN_PROP) begin
      cnt_raw = MIN_PROP;
    end
    if (cnt_raw > NUM_CH) begin
      cnt_raw = NUM_CH;
    end
  end

  // byte position and header tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_FIRST;
      header_ok_q <= 1'b0;
    end else if (in_acc) begin
      if (pos_eff == POS_FIRST) begin
        header_ok_q <= (byte_i.data_byte[6:0] == HEADER_CHAR);
        pos_q       <= POS_W'(1);
      end else if (pos_eff == POS_LAST) begin
        pos_q <= POS_FIRST;
      end else begin
        pos_q <= pos_eff + POS_W'(1);
      end
    end
  end

  // packet buffer, bytes 1..20, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && pos_eff != POS_FIRST && pos_eff != POS_LAST) begin
      store_mem[STORE_AW'(pos_eff - POS_W'(1))] <= byte_i.data_byte;
    end
    rd_data_q <= store_mem[rd_addr];
  end

  // side copies of the switch and hop bytes, burst-wide fields, low byte latch
  always_ff @(posedge clk_i) begin
    if (in_acc && pos_eff == POS_SWITCHES) begin
      switch_q <= byte_i.data_byte;
    end
    if (in_acc && pos_eff == POS_HOP) begin
      hop_byte_q <= byte_i.data_byte;
    end
    if (start_burst) begin
      cnt_q         <= cnt_raw;
      hop_period_q  <= HOP_P_W'(hop_byte_q[3:0]) + HOP_BASE;
      hop_present_q <= (byte_i.data_byte[7:4] == HOP_CHAN_TAG);
      hop_chan_q    <= byte_i.data_byte[3:0];
    end
    if (state_q == ST_RD_HI) begin
      lo_q <= rd_data_q;
    end
  end

  // channel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (start_burst) begin
      ch_q <= '0;
    end else if (out_acc) begin
      ch_q <= ch_q + CH_W'(1);
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_burst) state_d = ST_RD_LO;
      ST_RD_LO: state_d = ST_RD_HI;
      ST_RD_HI: state_d = ST_CALC;
      ST_CALC:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_d = res_last_q ? ST_IDLE : ST_RD_LO;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    calc_en  = 1'b0;
    rd_addr  = STORE_AW'(ch_q);
    case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_RD_LO: rd_addr  = STORE_AW'(ch_q);
      ST_RD_HI: rd_addr  = HI_NIB_BASE + STORE_AW'(ch_q[CH_W-1:1]);
      ST_CALC:  calc_en  = 1'b1;
      ST_OUT:   calc_en  = 1'b0;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // new channel value: proportional, switch or center
  assign hi_nib    = ch_q[0] ? rd_data_q[3:0] : rd_data_q[7:4];
  assign prop_val  = {hi_nib, lo_q};
  assign is_prop   = (ch_q < cnt_q);
  assign sw_off    = ch_q - cnt_q;
  assign is_switch = !is_prop && (sw_off < MAX_SWITCHES);
  assign in_range  = (prop_val > VAL_LOW_EXCL) && (prop_val < VAL_HIGH_EXCL);
  assign have      = !is_prop || in_range;

  always_comb begin
    if (is_prop) begin
      fresh = prop_val;
    end else if (is_switch) begin
      fresh = switch_q[sw_off[2:0]] ? SWITCH_ON : SWITCH_OFF;
    end else begin
      fresh = CENTER;
    end
  end

  // deadband with back-off toward the new value
  assign cur     = chan_out_q[ch_q[CH_IDX_W-1:0]];
  assign fresh_x = {1'b0, fresh};
  assign cur_x   = {1'b0, cur};

  always_comb begin
    new_val = cur;
    if (fresh_x + DEADBAND < cur_x) begin
      new_val = VAL_W'(fresh_x + BACKOFF);
    end else if (fresh_x > cur_x + DEADBAND) begin
      new_val = VAL_W'(fresh_x - BACKOFF);
    end
  end

  // held channel outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        chan_out_q[k] <= CENTER;
      end
    end else if (calc_en && have) begin
      chan_out_q[ch_q[CH_IDX_W-1:0]] <= new_val;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (calc_en) begin
      res_value_q <= have ? new_val : cur;
      res_last_q  <= (ch_q == LAST_CH);
    end
  end

  assign byte_i.ready = in_ready;

  assign result_o.valid               = (state_q == ST_OUT);
  assign result_o.channel_index       = ch_q;
  assign result_o.channel_value       = res_value_q;
  assign result_o.hop_period_ms       = hop_period_q;
  assign result_o.hop_channel_present = hop_present_q;
  assign result_o.hop_channel         = hop_chan_q;
  assign result_o.last                = res_last_q;

endmodule
